// ===== hdl/lpaq_pkg.sv =====
// shared types, codes and the ordering rank for the action queue
// no dependencies
`timescale 1ns / 1ps

package lpaq_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;
    localparam int KEY_W    = 32;
    localparam int IDS_W    = 40;
    localparam int RANK_W   = KEY_W + IDS_W;

    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // key: speed 31..16, priority 15..0
    typedef logic [KEY_W-1:0] key_t;
    // ids: subject 39..24, target 23..8, command 7..0
    typedef logic [IDS_W-1:0] ids_t;
    typedef logic [RANK_W-1:0] rank_t;

    typedef struct packed {
        logic data_valid;
        logic first;
        logic last;
    } scan_ctrl_t;

    // unsigned rank, smaller is served first
    function automatic rank_t rank_f(input key_t key, input ids_t ids);
        rank_f = {key[31], ~key[30:16], ~key[15], key[14:0], ids};
    endfunction

endpackage

// ===== hdl/lpaq_store.sv =====
// action storage: key and id memories, one write port, one registered read port
// depends on lpaq_pkg
`timescale 1ns / 1ps

module lpaq_store
    import lpaq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  key_t          wr_key,
    input  ids_t          wr_ids,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output key_t          rd_key,
    output ids_t          rd_ids
);

    key_t key_mem [DEPTH];
    ids_t ids_mem [DEPTH];
    key_t rd_key_reg;
    ids_t rd_ids_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_key;
            ids_mem[wr_addr] <= wr_ids;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_key_reg <= key_mem[rd_addr];
            rd_ids_reg <= ids_mem[rd_addr];
        end
    end

    assign rd_key = rd_key_reg;
    assign rd_ids = rd_ids_reg;

endmodule

// ===== hdl/lpaq_best.sv =====
// running best-entry tracker for the pop scan, also keeps the last entry
// depends on lpaq_pkg
`timescale 1ns / 1ps

module lpaq_best
    import lpaq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  scan_ctrl_t    ctrl,
    input  logic [AW-1:0] idx,
    input  key_t          key,
    input  ids_t          ids,
    output key_t          best_key,
    output ids_t          best_ids,
    output logic [AW-1:0] best_idx,
    output key_t          last_key,
    output ids_t          last_ids
);

    key_t          best_key_reg;
    ids_t          best_ids_reg;
    logic [AW-1:0] best_idx_reg;
    key_t          last_key_reg;
    ids_t          last_ids_reg;
    logic          better;

    // strict compare keeps the earliest of equal actions
    assign better = rank_f(key, ids) < rank_f(best_key_reg, best_ids_reg);

    always_ff @(posedge aclk) begin
        if (ctrl.data_valid && (ctrl.first || better)) begin
            best_key_reg <= key;
            best_ids_reg <= ids;
            best_idx_reg <= idx;
        end
        if (ctrl.data_valid && ctrl.last) begin
            last_key_reg <= key;
            last_ids_reg <= ids;
        end
    end

    assign best_key = best_key_reg;
    assign best_ids = best_ids_reg;
    assign best_idx = best_idx_reg;
    assign last_key = last_key_reg;
    assign last_ids = last_ids_reg;

endmodule

// ===== hdl/lexicographic_priority_action_queue.sv =====
// push, clear, unused mode, pop on empty: the request goes straight to the response state;
// pop of n actions: the single memory read port scans every stored action once, then one
// write moves the last action into the popped slot; one request at a time, a new item is
// taken only in idle once the last result has been handed on; a held result stalls input
// reset: count cleared, no clearing pass; the memories keep stale data
// depends on lpaq_pkg, lpaq_store, lpaq_best
`timescale 1ns / 1ps

module lexicographic_priority_action_queue
    import lpaq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [MODE_W-1:0]       s_mode,
    input  logic signed [15:0]      s_speed,
    input  logic signed [15:0]      s_priority_req,
    input  logic [15:0]             s_subject,
    input  logic [15:0]             s_target,
    input  logic [7:0]              s_command,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [STATUS_W-1:0]     m_status,
    output logic                    m_has_entry,
    output logic signed [15:0]      m_out_speed,
    output logic signed [15:0]      m_out_priority,
    output logic [15:0]             m_out_subject,
    output logic [15:0]             m_out_target,
    output logic [7:0]              m_out_command,
    output logic [OCC_W-1:0]        m_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_MOVE = 2'd2;
    localparam logic [1:0] ST_RESP = 2'd3;

    logic [1:0]    state_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [CW-1:0] iss_reg;
    logic          rd_pend_reg;
    logic [AW-1:0] rd_idx_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic                res_has_reg;
    key_t                res_key_reg;
    ids_t                res_ids_reg;
    logic [OCC_W-1:0]    res_occ_reg;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic                m_has_reg;
    key_t                m_key_reg;
    ids_t                m_ids_reg;
    logic [OCC_W-1:0]    m_occ_reg;

    logic          accept;
    logic          full;
    logic          out_free;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    key_t          wr_key;
    ids_t          wr_ids;
    key_t          rd_key;
    ids_t          rd_ids;
    key_t          best_key;
    ids_t          best_ids;
    logic [AW-1:0] best_idx;
    key_t          last_key;
    ids_t          last_ids;
    scan_ctrl_t    scan_ctrl;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign full     = (cnt_reg == CW'(DEPTH));
    assign out_free = !m_valid_reg || m_ready;
    assign rd_en    = (state_reg == ST_SCAN) && (iss_reg < cnt_reg);

    assign scan_ctrl.data_valid = rd_pend_reg;
    assign scan_ctrl.first      = (rd_idx_reg == '0);
    assign scan_ctrl.last       = rd_pend_reg && (CW'(rd_idx_reg) == cnt_reg - CW'(1));

    // push appends at the count, pop fills the hole with the last action
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg[AW-1:0];
        wr_key  = {s_speed, s_priority_req};
        wr_ids  = {s_subject, s_target, s_command};
        if (state_reg == ST_MOVE) begin
            wr_en   = 1'b1;
            wr_addr = best_idx;
            wr_key  = last_key;
            wr_ids  = last_ids;
        end else if (accept && s_mode == MODE_PUSH && !full) begin
            wr_en = 1'b1;
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (state_reg == ST_MOVE) begin
            cnt_next = cnt_reg - CW'(1);
        end else if (accept) begin
            if (s_mode == MODE_PUSH && !full) begin
                cnt_next = cnt_reg + CW'(1);
            end else if (s_mode == MODE_CLEAR) begin
                cnt_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            iss_reg     <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            rd_pend_reg <= rd_en;
            if (state_reg == ST_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    iss_reg <= '0;
                    if (accept) begin
                        if (s_mode == MODE_POP && cnt_reg != '0) begin
                            state_reg <= ST_SCAN;
                        end else begin
                            state_reg <= ST_RESP;
                        end
                    end
                end
                ST_SCAN: begin
                    if (rd_en) begin
                        iss_reg <= iss_reg + CW'(1);
                    end
                    if (scan_ctrl.last) begin
                        state_reg <= ST_MOVE;
                    end
                end
                ST_MOVE: begin
                    state_reg <= ST_RESP;
                end
                ST_RESP: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= iss_reg[AW-1:0];
        if (state_reg == ST_IDLE && accept) begin
            res_has_reg <= 1'b0;
            res_key_reg <= '0;
            res_ids_reg <= '0;
            res_occ_reg <= OCC_W'(cnt_next);
            if (s_mode == MODE_PUSH && full) begin
                res_status_reg <= STATUS_FULL;
            end else if (s_mode == MODE_POP && cnt_reg == '0) begin
                res_status_reg <= STATUS_EMPTY;
            end else begin
                res_status_reg <= STATUS_OK;
            end
        end else if (state_reg == ST_MOVE) begin
            res_status_reg <= STATUS_OK;
            res_has_reg    <= 1'b1;
            res_key_reg    <= best_key;
            res_ids_reg    <= best_ids;
            res_occ_reg    <= OCC_W'(cnt_next);
        end
        if (state_reg == ST_RESP && out_free) begin
            m_status_reg <= res_status_reg;
            m_has_reg    <= res_has_reg;
            m_key_reg    <= res_key_reg;
            m_ids_reg    <= res_ids_reg;
            m_occ_reg    <= res_occ_reg;
        end
    end

    lpaq_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_key  (wr_key),
        .wr_ids  (wr_ids),
        .rd_en   (rd_en),
        .rd_addr (iss_reg[AW-1:0]),
        .rd_key  (rd_key),
        .rd_ids  (rd_ids)
    );

    lpaq_best #(
        .DEPTH(DEPTH)
    ) u_best (
        .aclk     (aclk),
        .ctrl     (scan_ctrl),
        .idx      (rd_idx_reg),
        .key      (rd_key),
        .ids      (rd_ids),
        .best_key (best_key),
        .best_ids (best_ids),
        .best_idx (best_idx),
        .last_key (last_key),
        .last_ids (last_ids)
    );

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_has_entry    = m_has_reg;
    assign m_out_speed    = m_key_reg[31:16];
    assign m_out_priority = m_key_reg[15:0];
    assign m_out_subject  = m_ids_reg[39:24];
    assign m_out_target   = m_ids_reg[23:8];
    assign m_out_command  = m_ids_reg[7:0];
    assign m_occupancy    = m_occ_reg;

endmodule
